// File: design/wmmd_pkg.sv
// Shared widths, register indexes and controller/datapath interface types for the decimator.
`default_nettype none

package wmmd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SCNT_W   = 24;
  localparam int PCNT_W   = 20;
  localparam int CCNT_W   = 4;
  localparam int CHAN_W   = 3;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 5;
  localparam int PTS_W    = 7;
  localparam int OUT_DATA_W = 56;

  localparam logic [CCNT_W-1:0] MAX_CHANNELS = 4'd8;
  localparam logic [PTS_W-1:0]  MAX_PTS      = 7'd64;
  localparam logic [STEP_W-1:0] DIV_CFG_STEPS  = 5'd24;
  localparam logic [STEP_W-1:0] DIV_FRAC_STEPS = 5'd16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_PLUS_ONE  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MINUS_ONE = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT  = 2'd0,
    REG_POINT_COUNT   = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic cfg_write;
    logic div_cfg_start;
    logic cfg_load;
    logic accept;
    logic ds_step;
    logic scan_step;
    logic pt_div_start;
    logic pt_mul;
    logic pt_emit_interp;
    logic pt_emit_direct;
    logic pt_drop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic s_ge_p;
    logic ds_emit;
    logic scan_more;
    logic up_cond;
    logic need_interp;
    logic drop;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: design/wmmd_divider.sv
// Restoring divider, one quotient bit per cycle, used for the bin step and the interpolation fraction.
`default_nettype none

module wmmd_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [wmmd_pkg::PCNT_W-1:0]     divisor_i,
  input  wire logic [wmmd_pkg::PCNT_W-1:0]     rem_init_i,
  input  wire logic [wmmd_pkg::SCNT_W-1:0]     dividend_i,
  input  wire logic [wmmd_pkg::STEP_W-1:0]     steps_i,
  output logic                                 busy_o,
  output logic [wmmd_pkg::SCNT_W-1:0]          quot_o,
  output logic [wmmd_pkg::PCNT_W-1:0]          rem_o
);

  logic                          busy_q, busy_d;
  logic [wmmd_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [wmmd_pkg::PCNT_W-1:0]   rem_q, rem_d;
  logic [wmmd_pkg::SCNT_W-1:0]   dq_q, dq_d;
  logic [wmmd_pkg::PCNT_W:0]     trial, diff;
  logic                          ge;

  always_comb begin
    trial = {rem_q, dq_q[wmmd_pkg::SCNT_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      // The dividend register fills with quotient bits from the bottom.
      rem_d = ge ? diff[wmmd_pkg::PCNT_W-1:0] : trial[wmmd_pkg::PCNT_W-1:0];
      dq_d  = {dq_q[wmmd_pkg::SCNT_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: design/wmmd_datapath.sv
// Datapath: configuration, bin boundary tracking, min/max, interpolation and the result register.
`default_nettype none

module wmmd_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wmmd_pkg::cmd_t                      cmd_i,
  output wmmd_pkg::status_t                        status_o,
  input  wire logic [wmmd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [wmmd_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic [wmmd_pkg::SAMPLE_W-1:0]       sample_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [wmmd_pkg::OUT_DATA_W-1:0]          out_data_o,
  output logic                                     out_last_o,
  output logic                                     out_user_o
);

  typedef struct packed {
    logic [wmmd_pkg::SCNT_W-1:0] bq;
    logic [wmmd_pkg::PCNT_W-1:0] rem;
  } bnd_t;

  function automatic bnd_t advance(bnd_t b, logic [wmmd_pkg::SCNT_W-1:0] q0,
                                   logic [wmmd_pkg::PCNT_W-1:0] r0,
                                   logic [wmmd_pkg::PCNT_W-1:0] p);
    logic [wmmd_pkg::PCNT_W:0] rs;
    bnd_t nb;
    rs     = {1'b0, b.rem} + {1'b0, r0};
    nb.bq  = b.bq + q0;
    if (rs >= {1'b0, p}) begin
      rs    = rs - {1'b0, p};
      nb.bq = nb.bq + 1'b1;
    end
    nb.rem = rs[wmmd_pkg::PCNT_W-1:0];
    return nb;
  endfunction

  // A point at position bq + rem/p can be produced once sample bq+1 is present,
  // or at once when the position is whole, or on the last sample of the channel.
  function automatic logic up_cond_f(bnd_t b, logic [wmmd_pkg::PCNT_W-1:0] pp,
                                     logic [wmmd_pkg::PCNT_W-1:0] p,
                                     logic [wmmd_pkg::SCNT_W-1:0] k, logic last);
    return (pp < p) && ((b.bq < k) || ((b.bq == k) && (b.rem == '0)) || last);
  endfunction

  // Configuration and derived step.
  logic [wmmd_pkg::SCNT_W-1:0]   s_q, s_d;
  logic [wmmd_pkg::PCNT_W-1:0]   p_q, p_d;
  logic [wmmd_pkg::CCNT_W-1:0]   c_q, c_d;
  logic [wmmd_pkg::SCNT_W-1:0]   q0_q, q0_d;
  logic [wmmd_pkg::PCNT_W-1:0]   r0_q, r0_d;

  // Channel progress.
  logic [wmmd_pkg::SCNT_W-1:0]   k_q, k_d;
  logic [wmmd_pkg::PCNT_W-1:0]   pp_q, pp_d;
  logic [wmmd_pkg::CHAN_W-1:0]   chan_q, chan_d;
  logic signed [wmmd_pkg::SAMPLE_W-1:0] run_min_q, run_min_d, run_max_q, run_max_d;
  logic signed [wmmd_pkg::SAMPLE_W-1:0] prev_q, prev_d;
  logic [wmmd_pkg::SCNT_W-1:0]   bq_q, bq_d;
  logic [wmmd_pkg::PCNT_W-1:0]   rem_q, rem_d;

  // Per-sample working registers.
  logic signed [wmmd_pkg::SAMPLE_W-1:0] x_q, x_d;
  logic [wmmd_pkg::SCNT_W-1:0]   sbq_q, sbq_d;
  logic [wmmd_pkg::PCNT_W-1:0]   srem_q, srem_d;
  logic [wmmd_pkg::PCNT_W-1:0]   spp_q, spp_d;
  logic [wmmd_pkg::PTS_W-1:0]    cnt_q, cnt_d;
  logic [wmmd_pkg::PTS_W-1:0]    idx_q, idx_d;
  logic signed [33:0]            prod_q, prod_d;

  // Result register.
  logic                                  out_valid_q, out_valid_d;
  logic [wmmd_pkg::CHAN_W-1:0]           out_chan_q, out_chan_d;
  logic [wmmd_pkg::PCNT_W-1:0]           out_pidx_q, out_pidx_d;
  logic signed [wmmd_pkg::SAMPLE_W-1:0]  out_min_q, out_min_d, out_max_q, out_max_d;
  logic                                  out_last_q, out_last_d;
  logic                                  out_ovf_q, out_ovf_d;

  // Divider.
  logic                          div_start, div_busy;
  logic [wmmd_pkg::SCNT_W-1:0]   div_quot;
  logic [wmmd_pkg::PCNT_W-1:0]   div_rem;

  // Combinational helpers.
  bnd_t                          main_b, scan_b, adv_main, adv_scan;
  logic                          s_ge_p, last_sample, ds_emit, out_free, up_cond, scan_cond;
  logic [wmmd_pkg::SCNT_W:0]     k_inc;
  logic [wmmd_pkg::SCNT_W-1:0]   lastk;
  logic [wmmd_pkg::CCNT_W-1:0]   chan_inc;
  logic signed [wmmd_pkg::SAMPLE_W-1:0] nmin, nmax, interp_v;
  logic signed [wmmd_pkg::SAMPLE_W:0]   diff17, frac17;
  logic signed [33:0]            rsum;
  logic signed [17:0]            v18;
  logic [wmmd_pkg::PTS_W-1:0]    n_emit;
  logic                          up_last, finish, start_ch, load;

  wmmd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (p_q),
    .rem_init_i (cmd_i.pt_div_start ? rem_q : '0),
    .dividend_i (cmd_i.pt_div_start ? '0 : s_q),
    .steps_i    (cmd_i.pt_div_start ? wmmd_pkg::DIV_FRAC_STEPS : wmmd_pkg::DIV_CFG_STEPS),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign div_start = cmd_i.div_cfg_start | cmd_i.pt_div_start;

  always_comb begin
    main_b      = '{bq: bq_q, rem: rem_q};
    scan_b      = '{bq: sbq_q, rem: srem_q};
    adv_main    = advance(main_b, q0_q, r0_q, p_q);
    adv_scan    = advance(scan_b, q0_q, r0_q, p_q);
    s_ge_p      = (s_q >= {4'b0, p_q});
    k_inc       = {1'b0, k_q} + 1'b1;
    last_sample = (k_inc >= {1'b0, s_q});
    up_cond     = up_cond_f(main_b, pp_q, p_q, k_q, last_sample);
    scan_cond   = up_cond_f(scan_b, spp_q, p_q, k_q, last_sample);
    lastk       = (rem_q == '0) ? ((bq_q != '0) ? bq_q - 1'b1 : '0) : bq_q;
    ds_emit     = (pp_q < p_q) && (k_q == lastk);
    nmin        = (x_q < run_min_q) ? x_q : run_min_q;
    nmax        = (x_q > run_max_q) ? x_q : run_max_q;
    out_free    = !out_valid_q || out_ready_i;
    chan_inc    = {1'b0, chan_q} + 1'b1;
    n_emit      = (cnt_q > wmmd_pkg::MAX_PTS) ? wmmd_pkg::MAX_PTS : cnt_q;
    up_last     = (idx_q == n_emit - 1'b1);
    diff17      = {x_q[wmmd_pkg::SAMPLE_W-1], x_q} - {prev_q[wmmd_pkg::SAMPLE_W-1], prev_q};
    frac17      = {1'b0, div_quot[wmmd_pkg::FRAC_W-1:0]};
    // Rounded half up: a + floor((d*frac + 2^15) / 2^16).
    rsum        = prod_q + 34'sd32768;
    v18         = {{2{prev_q[wmmd_pkg::SAMPLE_W-1]}}, prev_q} + rsum[33:16];
    interp_v    = v18[wmmd_pkg::SAMPLE_W-1:0];
  end

  always_comb begin
    status_o.div_busy    = div_busy;
    status_o.s_ge_p      = s_ge_p;
    status_o.ds_emit     = ds_emit;
    status_o.scan_more   = (cnt_q <= wmmd_pkg::MAX_PTS) && scan_cond;
    status_o.up_cond     = up_cond;
    status_o.need_interp = (bq_q < k_q);
    status_o.drop        = (idx_q == wmmd_pkg::MAX_PTS);
    status_o.out_free    = out_free;
  end

  always_comb begin
    s_d = s_q;  p_d = p_q;  c_d = c_q;  q0_d = q0_q;  r0_d = r0_q;
    k_d = k_q;  pp_d = pp_q;  chan_d = chan_q;
    run_min_d = run_min_q;  run_max_d = run_max_q;  prev_d = prev_q;
    bq_d = bq_q;  rem_d = rem_q;
    x_d = x_q;  sbq_d = sbq_q;  srem_d = srem_q;  spp_d = spp_q;
    cnt_d = cnt_q;  idx_d = idx_q;  prod_d = prod_q;
    out_chan_d = out_chan_q;  out_pidx_d = out_pidx_q;
    out_min_d = out_min_q;  out_max_d = out_max_q;
    out_last_d = out_last_q;  out_ovf_d = out_ovf_q;
    finish = 1'b0;
    start_ch = 1'b0;
    load = 1'b0;

    if (cmd_i.cfg_write) begin
      unique case (cfg_index_i)
        wmmd_pkg::REG_SAMPLE_COUNT: begin
          s_d = (cfg_data_i == '0) ? 24'd1 : cfg_data_i;
        end
        wmmd_pkg::REG_POINT_COUNT: begin
          p_d = (cfg_data_i[wmmd_pkg::PCNT_W-1:0] == '0) ? 20'd1
              : cfg_data_i[wmmd_pkg::PCNT_W-1:0];
        end
        wmmd_pkg::REG_CHANNEL_COUNT: begin
          if (cfg_data_i[wmmd_pkg::CCNT_W-1:0] == '0) begin
            c_d = 4'd1;
          end else if (cfg_data_i[wmmd_pkg::CCNT_W-1:0] > wmmd_pkg::MAX_CHANNELS) begin
            c_d = wmmd_pkg::MAX_CHANNELS;
          end else begin
            c_d = cfg_data_i[wmmd_pkg::CCNT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.cfg_load) begin
      q0_d     = div_quot;
      r0_d     = div_rem;
      chan_d   = '0;
      start_ch = 1'b1;
    end

    if (cmd_i.accept) begin
      x_d    = sample_i;
      sbq_d  = bq_q;
      srem_d = rem_q;
      spp_d  = pp_q;
      cnt_d  = '0;
      idx_d  = '0;
    end

    if (cmd_i.scan_step) begin
      sbq_d  = adv_scan.bq;
      srem_d = adv_scan.rem;
      spp_d  = spp_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end

    if (cmd_i.ds_step) begin
      finish    = 1'b1;
      run_min_d = nmin;
      run_max_d = nmax;
      if (ds_emit) begin
        load       = 1'b1;
        out_min_d  = nmin;
        out_max_d  = nmax;
        out_last_d = 1'b1;
        out_ovf_d  = 1'b0;
        pp_d       = pp_q + 1'b1;
        // A boundary inside this sample makes it the first sample of the next bin too.
        run_min_d  = (rem_q != '0) ? x_q : wmmd_pkg::SAMPLE_PLUS_ONE;
        run_max_d  = (rem_q != '0) ? x_q : wmmd_pkg::SAMPLE_MINUS_ONE;
        bq_d       = adv_main.bq;
        rem_d      = adv_main.rem;
      end
    end

    if (cmd_i.pt_mul) begin
      prod_d = diff17 * frac17;
    end

    if (cmd_i.pt_emit_direct || cmd_i.pt_emit_interp) begin
      load       = 1'b1;
      out_min_d  = cmd_i.pt_emit_interp ? interp_v : x_q;
      out_max_d  = cmd_i.pt_emit_interp ? interp_v : x_q;
      out_last_d = up_last;
      out_ovf_d  = (cnt_q > wmmd_pkg::MAX_PTS);
      idx_d      = idx_q + 1'b1;
    end

    if (cmd_i.pt_emit_direct || cmd_i.pt_emit_interp || cmd_i.pt_drop) begin
      pp_d  = pp_q + 1'b1;
      bq_d  = adv_main.bq;
      rem_d = adv_main.rem;
    end

    if (load) begin
      out_chan_d = chan_q;
      out_pidx_d = pp_q;
    end

    if (cmd_i.finish) begin
      finish = 1'b1;
    end

    if (finish) begin
      prev_d = x_q;
      k_d    = k_inc[wmmd_pkg::SCNT_W-1:0];
      if (last_sample) begin
        chan_d   = (chan_inc >= c_q) ? '0 : chan_inc[wmmd_pkg::CHAN_W-1:0];
        start_ch = 1'b1;
      end
    end

    if (start_ch) begin
      k_d       = '0;
      pp_d      = '0;
      run_min_d = wmmd_pkg::SAMPLE_PLUS_ONE;
      run_max_d = wmmd_pkg::SAMPLE_MINUS_ONE;
      prev_d    = '0;
      bq_d      = s_ge_p ? q0_d : '0;
      rem_d     = s_ge_p ? r0_d : '0;
    end

    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q         <= 24'd1;
      p_q         <= 20'd1;
      c_q         <= 4'd1;
      q0_q        <= 24'd1;
      r0_q        <= '0;
      k_q         <= '0;
      pp_q        <= '0;
      chan_q      <= '0;
      run_min_q   <= wmmd_pkg::SAMPLE_PLUS_ONE;
      run_max_q   <= wmmd_pkg::SAMPLE_MINUS_ONE;
      prev_q      <= '0;
      bq_q        <= 24'd1;
      rem_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_q         <= s_d;
      p_q         <= p_d;
      c_q         <= c_d;
      q0_q        <= q0_d;
      r0_q        <= r0_d;
      k_q         <= k_d;
      pp_q        <= pp_d;
      chan_q      <= chan_d;
      run_min_q   <= run_min_d;
      run_max_q   <= run_max_d;
      prev_q      <= prev_d;
      bq_q        <= bq_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    sbq_q      <= sbq_d;
    srem_q     <= srem_d;
    spp_q      <= spp_d;
    prod_q     <= prod_d;
    out_chan_q <= out_chan_d;
    out_pidx_q <= out_pidx_d;
    out_min_q  <= out_min_d;
    out_max_q  <= out_max_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_max_q, out_min_q, out_pidx_q, out_chan_q};
  assign out_last_o  = out_last_q;
  assign out_user_o  = out_ovf_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_valid_q |-> out_ready_i)
    else $error("result register loaded while a result is still pending");

  a_drop_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pt_drop |-> (idx_q == wmmd_pkg::MAX_PTS) && (cnt_q > wmmd_pkg::MAX_PTS))
    else $error("point dropped before the per-sample limit was reached");

  a_emit_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pt_emit_direct || cmd_i.pt_emit_interp) |-> (idx_q < cnt_q))
    else $error("more points emitted than the scan pass counted");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// File: design/wmmd_controller.sv
// Controller state machine that sequences configuration, bin steps and interpolated points.
`default_nettype none

module wmmd_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [wmmd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire wmmd_pkg::status_t                status_i,
  output wmmd_pkg::cmd_t                        cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DS,
    ST_SCAN,
    ST_UP_CHECK,
    ST_UP_DIV,
    ST_UP_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   restart;

  always_comb begin
    unique case (cfg_index_i) inside
      wmmd_pkg::REG_SAMPLE_COUNT, wmmd_pkg::REG_POINT_COUNT,
      wmmd_pkg::REG_CHANNEL_COUNT: restart = 1'b1;
      default:                     restart = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cfg_ready_o = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
          if (restart) begin
            state_d = ST_DIV_START;
          end
        end else if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.s_ge_p ? ST_DS : ST_SCAN;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_cfg_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.cfg_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DS: begin
        if (!status_i.ds_emit || status_i.out_free) begin
          cmd_o.ds_step = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Count the points this sample yields, up to one past the limit.
        if (status_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_d = ST_UP_CHECK;
        end
      end
      ST_UP_CHECK: begin
        if (!status_i.up_cond) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.drop) begin
          cmd_o.pt_drop = 1'b1;
        end else if (status_i.need_interp) begin
          if (!status_i.div_busy) begin
            cmd_o.pt_div_start = 1'b1;
            state_d = ST_UP_DIV;
          end
        end else if (status_i.out_free) begin
          cmd_o.pt_emit_direct = 1'b1;
        end
      end
      ST_UP_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.pt_mul = 1'b1;
          state_d = ST_UP_EMIT;
        end
      end
      ST_UP_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.pt_emit_interp = 1'b1;
          state_d = ST_UP_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: design/waveform_min_max_decimator_unit.sv
// Top level of the min/max waveform decimator: controller, datapath and stream ports.
// Bin mode (samples >= points): a sample is accepted and stepped; a step closing a bin
// waits for a free result register and loads it. Interpolation mode: a count pass of up
// to 65 points; then each point is emitted directly, dropped, or interpolated by a fraction
// from the divider. A count register write restarts at channel 0 after a bin-step division.
// Asynchronous active-low reset restores one sample, point and channel with no clearing pass.
`default_nettype none

module waveform_min_max_decimator_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [wmmd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [wmmd_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] sample
  input  wire logic [wmmd_pkg::SAMPLE_W-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [2:0] channel, [22:3] point_index, [38:23] min_value, [54:39] max_value, [55] zero
  output logic [wmmd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tlast,
  // [0] overflow
  output logic                                    m_axis_tuser
);

  wmmd_pkg::cmd_t    cmd;
  wmmd_pkg::status_t status;

  wmmd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wmmd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
